// File: rtl/charset_text_tokenizer_defines.svh
// assertion macros for the charset text tokenizer
`ifndef CHARSET_TEXT_TOKENIZER_DEFINES_SVH
`define CHARSET_TEXT_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTT_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication failed");
`define CTT_ASSERT_NEVER(label, clk, rst, e) \
   label: assert property (@(posedge clk) disable iff (rst) !(e)) \
      else $error("forbidden condition");
`else
`define CTT_ASSERT_IMPLY(label, clk, rst, a, c)
`define CTT_ASSERT_NEVER(label, clk, rst, e)
`endif
`endif

// File: rtl/ctt_pkg.sv
// shared types, constants, token table and helper functions of the tokenizer
package ctt_pkg;
   localparam int WINDOW_CHARS = 6;
   localparam int TABLE_ENTRIES = 256;
   localparam int FILL_W = $clog2(WINDOW_CHARS + 1);
   localparam int TOK_MAX_LEN = 6;
   localparam int IN_DEPTH = 4;
   localparam int IN_PTR_W = 2;
   localparam int IN_CNT_W = 3;
   localparam int RSP_DEPTH = 2;
   localparam logic [7:0] BACKSLASH = 8'h5c;
   localparam logic [7:0] CODE_MASK = 8'hff;
   localparam int ESC_LEN = 3;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic       valid;
      item_type   item;
   } head_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       cannot_encode;
      logic       run_end;
   } rsp_type;

   typedef logic [WINDOW_CHARS-1:0][7:0] window_type;

   function automatic logic [7:0] fold_case(logic [7:0] c);
      if (c >= "a" && c <= "z") return c - 8'd32;
      return c;
   endfunction

   function automatic logic [4:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic logic [8*TOK_MAX_LEN-1:0] tok_str(int i);
      logic [8*TOK_MAX_LEN-1:0] s;
      s = '0;
      case (i)
         0: s = " "; 1: s = "\\' "; 2: s = "\\ '"; 3: s = "\\''";
         4: s = "\\. "; 5: s = "\\: "; 6: s = "\\.'"; 7: s = "\\:'";
         8: s = "\\##"; 9: s = "\\,,"; 10: s = "\\~~"; 11: s = "\"";
         12: s = "\\0c"; 13: s = "$"; 14: s = ":"; 15: s = "?";
         16: s = "("; 17: s = ")"; 18: s = ">"; 19: s = "<";
         20: s = "="; 21: s = "+"; 22: s = "-"; 23: s = "*";
         24: s = "/"; 25: s = ";"; 26: s = ","; 27: s = ".";
         28: s = "0"; 29: s = "1"; 30: s = "2"; 31: s = "3";
         32: s = "4"; 33: s = "5"; 34: s = "6"; 35: s = "7";
         36: s = "8"; 37: s = "9"; 38: s = "A"; 39: s = "B";
         40: s = "C"; 41: s = "D"; 42: s = "E"; 43: s = "F";
         44: s = "G"; 45: s = "H"; 46: s = "I"; 47: s = "J";
         48: s = "K"; 49: s = "L"; 50: s = "M"; 51: s = "N";
         52: s = "O"; 53: s = "P"; 54: s = "Q"; 55: s = "R";
         56: s = "S"; 57: s = "T"; 58: s = "U"; 59: s = "V";
         60: s = "W"; 61: s = "X"; 62: s = "Y"; 63: s = "Z";
         64: s = "RND"; 65: s = "INKEY$"; 66: s = "PI"; 67: s = "\\43";
         68: s = "\\44"; 69: s = "\\45"; 70: s = "\\46"; 71: s = "\\47";
         72: s = "\\48"; 73: s = "\\49"; 74: s = "\\4a"; 75: s = "\\4b";
         76: s = "\\4c"; 77: s = "\\4d"; 78: s = "\\4e"; 79: s = "\\4f";
         80: s = "\\50"; 81: s = "\\51"; 82: s = "\\52"; 83: s = "\\53";
         84: s = "\\54"; 85: s = "\\55"; 86: s = "\\56"; 87: s = "\\57";
         88: s = "\\58"; 89: s = "\\59"; 90: s = "\\5a"; 91: s = "\\5b";
         92: s = "\\5c"; 93: s = "\\5d"; 94: s = "\\5e"; 95: s = "\\5f";
         96: s = "\\60"; 97: s = "\\61"; 98: s = "\\62"; 99: s = "\\63";
         100: s = "\\64"; 101: s = "\\65"; 102: s = "\\66"; 103: s = "\\67";
         104: s = "\\68"; 105: s = "\\69"; 106: s = "\\6a"; 107: s = "\\6b";
         108: s = "\\6c"; 109: s = "\\6d"; 110: s = "\\6e"; 111: s = "\\6f";
         112: s = "\\70"; 113: s = "\\71"; 114: s = "\\72"; 115: s = "\\73";
         116: s = "\\74"; 117: s = "\\75"; 118: s = "\\76"; 119: s = "\\77";
         120: s = "\\78"; 121: s = "\\79"; 122: s = "\\7a"; 123: s = "\\7b";
         124: s = "\\7c"; 125: s = "\\7d"; 126: s = "\\7e"; 127: s = "\\7f";
         128: s = "\\::"; 129: s = "\\.:"; 130: s = "\\:."; 131: s = "\\..";
         132: s = "\\':"; 133: s = "\\ :"; 134: s = "\\'."; 135: s = "\\ .";
         136: s = "\\@@"; 137: s = "\\;;"; 138: s = "\\!!"; 139: s = "%\"";
         140: s = "\\8c"; 141: s = "%$"; 142: s = "%:"; 143: s = "%?";
         144: s = "%("; 145: s = "%)"; 146: s = "%>"; 147: s = "%<";
         148: s = "%="; 149: s = "%+"; 150: s = "%-"; 151: s = "%*";
         152: s = "%/"; 153: s = "%;"; 154: s = "%,"; 155: s = "%.";
         156: s = "%0"; 157: s = "%1"; 158: s = "%2"; 159: s = "%3";
         160: s = "%4"; 161: s = "%5"; 162: s = "%6"; 163: s = "%7";
         164: s = "%8"; 165: s = "%9"; 166: s = "%A"; 167: s = "%B";
         168: s = "%C"; 169: s = "%D"; 170: s = "%E"; 171: s = "%F";
         172: s = "%G"; 173: s = "%H"; 174: s = "%I"; 175: s = "%J";
         176: s = "%K"; 177: s = "%L"; 178: s = "%M"; 179: s = "%N";
         180: s = "%O"; 181: s = "%P"; 182: s = "%Q"; 183: s = "%R";
         184: s = "%S"; 185: s = "%T"; 186: s = "%U"; 187: s = "%V";
         188: s = "%W"; 189: s = "%X"; 190: s = "%Y"; 191: s = "%Z";
         192: s = "\\\""; 193: s = "AT"; 194: s = "TAB"; 195: s = "\\c3";
         196: s = "CODE"; 197: s = "VAL"; 198: s = "LEN"; 199: s = "SIN";
         200: s = "COS"; 201: s = "TAN"; 202: s = "ASN"; 203: s = "ACS";
         204: s = "ATN"; 205: s = "LN"; 206: s = "EXP"; 207: s = "INT";
         208: s = "SQR"; 209: s = "SGN"; 210: s = "ABS"; 211: s = "PEEK";
         212: s = "USR"; 213: s = "STR$"; 214: s = "CHR$"; 215: s = "NOT";
         216: s = "**"; 217: s = "OR"; 218: s = "AND"; 219: s = "<=";
         220: s = ">="; 221: s = "<>"; 222: s = "THEN"; 223: s = "TO";
         224: s = "STEP"; 225: s = "LPRINT"; 226: s = "LLIST"; 227: s = "STOP";
         228: s = "SLOW"; 229: s = "FAST"; 230: s = "NEW"; 231: s = "SCROLL";
         232: s = "CONT"; 233: s = "DIM"; 234: s = "REM"; 235: s = "FOR";
         236: s = "GOTO"; 237: s = "GOSUB"; 238: s = "INPUT"; 239: s = "LOAD";
         240: s = "LIST"; 241: s = "LET"; 242: s = "PAUSE"; 243: s = "NEXT";
         244: s = "POKE"; 245: s = "PRINT"; 246: s = "PLOT"; 247: s = "RUN";
         248: s = "SAVE"; 249: s = "RAND"; 250: s = "IF"; 251: s = "CLS";
         252: s = "UNPLOT"; 253: s = "CLEAR"; 254: s = "RETURN"; 255: s = "COPY";
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic int tok_len(logic [8*TOK_MAX_LEN-1:0] s);
      int n;
      n = 0;
      for (int b = 0; b < TOK_MAX_LEN; b++) begin
         if (s[8*b +: 8] != 8'd0) n = b + 1;
      end
      return n;
   endfunction

   function automatic logic tok_match(window_type w, logic [FILL_W-1:0] fill,
                                      logic [8*TOK_MAX_LEN-1:0] s, int len);
      logic ok;
      ok = (len <= int'(fill));
      for (int j = 0; j < TOK_MAX_LEN; j++) begin
         if (j < len) begin
            if (fold_case(w[j]) != fold_case(s[8*(len-1-j) +: 8])) ok = 1'b0;
         end
      end
      return ok;
   endfunction
endpackage

// File: rtl/charset_text_tokenizer.sv
// top level of the charset text tokenizer
// One character word is taken per cycle while no flush runs and the result
// queue has room; a token is decided once the six character lookahead window
// is full, so a steady stream gives one result word per token. The end mark
// flushes the window through the parallel matchers at one token per cycle
// while the result queue has room; the input queue keeps taking characters.
// An error result ends the string and later characters up to its end give nothing.
`include "charset_text_tokenizer_defines.svh"
module charset_text_tokenizer import ctt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_cannot_encode,
   output logic       rsp_run_end
);
   item_type  item;
   head_type  head;
   logic      head_pop;
   rsp_type   rsp;

   assign item.text_char = req_text_char;
   assign item.end_of_text = req_end_of_text;

   ctt_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .item(item), .head(head), .head_pop(head_pop)
   );

   ctt_back u_back (
      .clock(clock), .reset(reset), .head(head), .head_pop(head_pop),
      .rsp(rsp), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop)
   );

   assign rsp_code_byte = rsp.code_byte;
   assign rsp_cannot_encode = rsp.cannot_encode;
   assign rsp_run_end = rsp.run_end;

   `CTT_ASSERT_IMPLY(a_err_ends_run, clock, reset, !rsp_empty && rsp_cannot_encode, rsp_run_end)
   `CTT_ASSERT_IMPLY(a_err_code_zero, clock, reset, !rsp_empty && rsp_cannot_encode, rsp_code_byte == 8'd0)
   `CTT_ASSERT_NEVER(a_pop_without_head, clock, reset, head_pop && !head.valid)
endmodule

// File: rtl/ctt_front.sv
// front end: accepts characters into a short queue toward the matcher
module ctt_front import ctt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  item_type   item,
   output head_type   head,
   input  logic       head_pop
);
   item_type               mem_ff [IN_DEPTH];
   logic [IN_PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [IN_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full = (cnt_ff == IN_CNT_W'(IN_DEPTH));
   assign do_push = push && !full;
   assign do_pop = head_pop && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.item = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff + IN_PTR_W'(do_push);
      rd_in = rd_ff + IN_PTR_W'(do_pop);
      cnt_in = cnt_ff + IN_CNT_W'(do_push) - IN_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= item;
   end
endmodule

// File: rtl/ctt_back.sv
// back end: lookahead window, parallel token matchers and result queue
module ctt_back import ctt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       head_pop,
   output rsp_type    rsp,
   output logic       rsp_empty,
   input  logic       rsp_pop
);
   window_type             win_ff, win_in, cw, nw;
   logic [FILL_W-1:0]      fill_ff, fill_in, cf, nf, tlen;
   logic                   failed_ff, failed_in, flush_ff, flush_in;
   rsp_type                q_ff [RSP_DEPTH];
   rsp_type                q_in [RSP_DEPTH];
   rsp_type                new_rsp;
   logic [1:0]             qcnt_ff, qcnt_in, qcnt_mid;
   logic                   pop_ok, room, step_flush, step_char, do_match, eot_ctx;
   logic [TABLE_ENTRIES-1:0] hit;
   logic [4:0]             hx1, hx2;
   logic                   esc_ok, any_hit;
   logic [7:0]             code;

   assign rsp_empty = (qcnt_ff == 2'd0);
   assign rsp = q_ff[0];
   assign pop_ok = rsp_pop && !rsp_empty;
   assign room = (qcnt_ff < 2'(RSP_DEPTH)) || pop_ok;

   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_tok
      localparam logic [8*TOK_MAX_LEN-1:0] TokS = tok_str(gi);
      localparam int TokL = tok_len(TokS);
      assign hit[gi] = tok_match(cw, cf, TokS, TokL);
   end

   always_comb begin
      step_flush = flush_ff && room;
      step_char = !flush_ff && head.valid && room;
      head_pop = step_char;
      eot_ctx = flush_ff || head.item.end_of_text;
      cw = win_ff;
      cf = fill_ff;
      if (!flush_ff) begin
         cw[fill_ff] = head.item.text_char;
         cf = fill_ff + FILL_W'(1);
      end
      do_match = step_flush || (step_char && !failed_ff &&
                 (cf == FILL_W'(WINDOW_CHARS) || head.item.end_of_text));
      hx1 = hex_value(cw[1]);
      hx2 = hex_value(cw[2]);
      esc_ok = (cf >= FILL_W'(ESC_LEN)) && (cw[0] == BACKSLASH) && hx1[4] && hx2[4];
      any_hit = esc_ok || (hit != '0);
      code = {hx1[3:0], hx2[3:0]};
      tlen = FILL_W'(ESC_LEN);
      if (!esc_ok) begin
         code = '0;
         tlen = '0;
         for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
               code = 8'(i) & CODE_MASK;
               tlen = FILL_W'(tok_len(tok_str(i)));
            end
         end
      end
      nw = cw;
      for (int k = 0; k < WINDOW_CHARS; k++) begin
         if (k + int'(tlen) < WINDOW_CHARS) nw[k] = cw[k + int'(tlen)];
      end
      nf = cf - tlen;

      win_in = win_ff;
      fill_in = fill_ff;
      failed_in = failed_ff;
      flush_in = flush_ff;
      new_rsp = '0;
      if (do_match) begin
         if (!any_hit) begin
            new_rsp.cannot_encode = 1'b1;
            new_rsp.run_end = 1'b1;
            fill_in = '0;
            failed_in = !eot_ctx;
            flush_in = 1'b0;
         end else begin
            new_rsp.code_byte = code;
            new_rsp.run_end = eot_ctx && (nf == '0);
            win_in = nw;
            fill_in = nf;
            flush_in = eot_ctx && (nf != '0);
         end
      end else if (step_char) begin
         if (failed_ff) begin
            if (head.item.end_of_text) begin
               failed_in = 1'b0;
               fill_in = '0;
            end
         end else begin
            win_in = cw;
            fill_in = cf;
         end
      end

      qcnt_mid = qcnt_ff - 2'(pop_ok);
      qcnt_in = qcnt_mid + 2'(do_match);

      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop_ok) q_in[0] = q_ff[1];
      if (do_match) q_in[qcnt_mid[0]] = new_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         failed_ff <= 1'b0;
         flush_ff <= 1'b0;
         qcnt_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         failed_ff <= failed_in;
         flush_ff <= flush_in;
         qcnt_ff <= qcnt_in;
      end
      win_ff <= win_in;
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end
endmodule

// File: dv/charset_text_tokenizer_test.sv
// self-checking testbench for the charset text tokenizer with its own token predictor
module charset_text_tokenizer_test import ctt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int CALM_TAIL = 50;

   typedef struct {
      bit [7:0] ch;
      bit       eot;
      bit       drain_first;
   } text_word_t;

   typedef struct {
      logic [7:0] code;
      logic       bad;
      logic       last;
   } code_word_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_text_char = 8'h20;
   logic       req_end_of_text = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_code_byte;
   logic       rsp_cannot_encode;
   logic       rsp_run_end;

   charset_text_tokenizer dut (.*);

   always #5 clock = ~clock;

   string token_text[256] = '{
      " ", "\\' ", "\\ '", "\\''", "\\. ", "\\: ", "\\.'", "\\:'",
      "\\##", "\\,,", "\\~~", "\"", "\\0c", "$", ":", "?",
      "(", ")", ">", "<", "=", "+", "-", "*",
      "/", ";", ",", ".", "0", "1", "2", "3",
      "4", "5", "6", "7", "8", "9", "A", "B",
      "C", "D", "E", "F", "G", "H", "I", "J",
      "K", "L", "M", "N", "O", "P", "Q", "R",
      "S", "T", "U", "V", "W", "X", "Y", "Z",
      "RND", "INKEY$", "PI", "\\43", "\\44", "\\45", "\\46", "\\47",
      "\\48", "\\49", "\\4a", "\\4b", "\\4c", "\\4d", "\\4e", "\\4f",
      "\\50", "\\51", "\\52", "\\53", "\\54", "\\55", "\\56", "\\57",
      "\\58", "\\59", "\\5a", "\\5b", "\\5c", "\\5d", "\\5e", "\\5f",
      "\\60", "\\61", "\\62", "\\63", "\\64", "\\65", "\\66", "\\67",
      "\\68", "\\69", "\\6a", "\\6b", "\\6c", "\\6d", "\\6e", "\\6f",
      "\\70", "\\71", "\\72", "\\73", "\\74", "\\75", "\\76", "\\77",
      "\\78", "\\79", "\\7a", "\\7b", "\\7c", "\\7d", "\\7e", "\\7f",
      "\\::", "\\.:", "\\:.", "\\..", "\\':", "\\ :", "\\'.", "\\ .",
      "\\@@", "\\;;", "\\!!", "%\"", "\\8c", "%$", "%:", "%?",
      "%(", "%)", "%>", "%<", "%=", "%+", "%-", "%*",
      "%/", "%;", "%,", "%.", "%0", "%1", "%2", "%3",
      "%4", "%5", "%6", "%7", "%8", "%9", "%A", "%B",
      "%C", "%D", "%E", "%F", "%G", "%H", "%I", "%J",
      "%K", "%L", "%M", "%N", "%O", "%P", "%Q", "%R",
      "%S", "%T", "%U", "%V", "%W", "%X", "%Y", "%Z",
      "\\\"", "AT", "TAB", "\\c3", "CODE", "VAL", "LEN", "SIN",
      "COS", "TAN", "ASN", "ACS", "ATN", "LN", "EXP", "INT",
      "SQR", "SGN", "ABS", "PEEK", "USR", "STR$", "CHR$", "NOT",
      "**", "OR", "AND", "<=", ">=", "<>", "THEN", "TO",
      "STEP", "LPRINT", "LLIST", "STOP", "SLOW", "FAST", "NEW", "SCROLL",
      "CONT", "DIM", "REM", "FOR", "GOTO", "GOSUB", "INPUT", "LOAD",
      "LIST", "LET", "PAUSE", "NEXT", "POKE", "PRINT", "PLOT", "RUN",
      "SAVE", "RAND", "IF", "CLS", "UNPLOT", "CLEAR", "RETURN", "COPY"
   };

   text_word_t pending_text[$];
   code_word_t expected_codes[$];
   bit [7:0]   window_chars[WINDOW_CHARS];
   int         window_count = 0;
   bit         string_failed = 1'b0;
   int         error_count = 0;
   int         chars_taken = 0;
   int         codes_seen = 0;
   int         bad_seen = 0;
   int         strings_sent = 0;
   int         quiet_cycles = 0;

   function automatic bit [7:0] upper_of(bit [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic int hex_of(bit [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic void expect_code(bit [7:0] code, bit bad, bit last);
      code_word_t w;
      w.code = code;
      w.bad = bad;
      w.last = last;
      expected_codes.insert(expected_codes.size(), w);
   endfunction

   function automatic void shift_window(int n);
      for (int i = 0; i + n < window_count; i++) window_chars[i] = window_chars[i + n];
      window_count -= n;
   endfunction

   function automatic bit match_token(output bit [7:0] code);
      int hi, lo, len;
      bit hit;
      if (window_count >= 3 && window_chars[0] == BACKSLASH) begin
         hi = hex_of(window_chars[1]);
         lo = hex_of(window_chars[2]);
         if (hi >= 0 && lo >= 0) begin
            code = 8'(hi * 16 + lo);
            shift_window(3);
            return 1'b1;
         end
      end
      for (int i = 0; i < 256; i++) begin
         len = token_text[i].len();
         hit = (len <= window_count);
         for (int j = 0; hit && j < len; j++)
            if (upper_of(window_chars[j]) != upper_of(token_text[i][j])) hit = 1'b0;
         if (hit) begin
            code = 8'(i);
            shift_window(len);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void tokenize_char(bit [7:0] ch, bit eot);
      bit [7:0] code;
      int made;
      made = 0;
      if (string_failed) begin
         if (eot) begin
            string_failed = 1'b0;
            window_count = 0;
         end
         return;
      end
      if (window_count < WINDOW_CHARS) begin
         window_chars[window_count] = ch;
         window_count++;
      end
      while (window_count > 0 && (eot || window_count >= WINDOW_CHARS)) begin
         if (!match_token(code)) begin
            expect_code(8'h00, 1'b1, 1'b1);
            window_count = 0;
            if (!eot) string_failed = 1'b1;
            return;
         end
         expect_code(code, 1'b0, 1'b0);
         made++;
      end
      if (eot && made > 0) expected_codes[expected_codes.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void queue_string(string s, bit drain_first = 1'b0);
      text_word_t w;
      for (int i = 0; i < s.len(); i++) begin
         w.ch = s[i];
         w.eot = (i == s.len() - 1);
         w.drain_first = drain_first && i == 0;
         pending_text.insert(pending_text.size(), w);
      end
      strings_sent++;
   endfunction

   function automatic string mixed_case(string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(0, 1)) r[i] = r[i] + 8'd32;
      return r;
   endfunction

   function automatic string hex_digit();
      string d;
      int k;
      d = "0123456789abcdefABCDEF";
      k = $urandom_range(0, 21);
      return d.substr(k, k);
   endfunction

   function automatic string random_string();
      string s, c;
      int pick;
      s = "";
      c = " ";
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            c[0] = 8'($urandom_range(1, 255));
            s = {s, c};
         end
         return s;
      end
      repeat ($urandom_range(1, 10)) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) s = {s, mixed_case(token_text[$urandom_range(0, 255)])};
         else if (pick < 93) s = {s, "\\", hex_digit(), hex_digit()};
         else if (pick < 96) s = {s, "\\", hex_digit()};
         else begin
            c[0] = 8'($urandom_range(1, 255));
            s = {s, c};
         end
      end
      return s;
   endfunction

   always @(posedge clock) begin : sender
      text_word_t nxt;
      bit offer;
      int gap;
      if (reset) begin
         req_push <= 1'b0;
         gap = 0;
      end else begin
         offer = req_push;
         if (req_push && !req_full) begin
            tokenize_char(req_text_char, req_end_of_text);
            chars_taken++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap > 0) gap--;
            else if (pending_text.size() > CALM_TAIL && $urandom_range(0, 6) == 0)
               gap = $urandom_range(1, 11);
            else if (pending_text.size() > 0 &&
                     !(pending_text[0].drain_first && expected_codes.size() != 0)) begin
               nxt = pending_text.pop_front();
               req_text_char <= nxt.ch;
               req_end_of_text <= nxt.eot;
               offer = 1'b1;
            end
         end
         req_push <= offer;
      end
   end

   always @(posedge clock) begin : receiver
      code_word_t want;
      int gap, hold;
      bit held_once;
      if (reset) begin
         rsp_pop <= 1'b0;
         gap = 0;
         hold = 0;
         held_once = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            codes_seen++;
            if (rsp_cannot_encode) bad_seen++;
            if (expected_codes.size() == 0)
               report_mismatch($sformatf("unexpected word code %02h", rsp_code_byte));
            else begin
               want = expected_codes.pop_front();
               if (rsp_code_byte !== want.code)
                  report_mismatch($sformatf("code %02h, want %02h", rsp_code_byte, want.code));
               if (rsp_cannot_encode !== want.bad)
                  report_mismatch($sformatf("cannot_encode %b, want %b",
                                            rsp_cannot_encode, want.bad));
               if (rsp_run_end !== want.last)
                  report_mismatch($sformatf("run_end %b, want %b", rsp_run_end, want.last));
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (!held_once && codes_seen >= 60) begin
            held_once = 1'b1;
            hold = 300;
            rsp_pop <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_pop <= 1'b0;
         end else if (pending_text.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_pop <= 1'b0;
         end else
            rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_codes.size());
         $display("DONE: errors detected");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      string s;
      queue_string("PRINT");
      queue_string("print");
      queue_string("\\FF");
      queue_string("\\00");
      queue_string("&AB");
      queue_string("\\5");
      queue_string("%");
      queue_string("A");
      s = " ";
      s[0] = 8'h01;
      queue_string(s);
      s[0] = 8'hff;
      queue_string(s);
      while (pending_text.size() < 300)
         queue_string(random_string(), strings_sent % 15 == 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_text.size() != 0 || req_push || expected_codes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_codes.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_codes.size()));
      $display("%0d strings, %0d characters in, %0d codes out (%0d cannot-encode)",
               strings_sent, chars_taken, codes_seen, bad_seen);
      $display("directed escapes, case folding and errors, then random token strings");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_front.sv
rtl/ctt_back.sv
rtl/charset_text_tokenizer.sv
dv/charset_text_tokenizer_test.sv
